@@ src/pcxrle_pkg.sv @@
// Shared types and constants for the PCX run-length row encoder.
`timescale 1ns / 1ps
`default_nettype none

package pcxrle_pkg;

  localparam logic [5:0] RUN_MAX    = 6'd63;
  localparam logic [7:0] RUN_MARK   = 8'hC0;
  localparam int         FIFO_DEPTH = 4;

  // one closed run, as handed from the front end to the byte emitter
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] count;
    logic       last;
  } run_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic {
    BK_HEAD,
    BK_BYTE
  } bk_state_t;

endpackage

`default_nettype wire

@@ src/pcxrle_front.sv @@
// Front end: tracks the open run and turns each input byte into closed-run records.
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_valid,
  input  wire                   cfg_data,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_byte,
  input  wire                   in_end,
  input  wire  pcxrle_pkg::fifo_stat_t q_stat,
  output logic                  push,
  output pcxrle_pkg::run_rec_t  push_rec
);

  logic                 pad_r;
  logic [7:0]           run_byte_r, run_byte_nxt;
  logic [5:0]           run_count_r, run_count_nxt;
  logic                 run_open_r, run_open_nxt;
  logic                 odd_r, odd_nxt;
  pcxrle_pkg::run_rec_t p0_r, p0_nxt, p1_r, p1_nxt;
  logic [1:0]           pend_cnt_r, pend_cnt_nxt;

  logic                 accept;
  logic                 match;
  logic                 v1, v2, pad_feed;
  logic [5:0]           cnt_a, cnt_b;
  pcxrle_pkg::run_rec_t r1, r2, r3, first;

  assign in_ready = (pend_cnt_r == 2'd0) && !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    match    = run_open_r && (in_byte == run_byte_r) && (run_count_r < pcxrle_pkg::RUN_MAX);
    v1       = run_open_r && !match;
    r1       = '{data: run_byte_r, count: run_count_r, last: !in_end};
    cnt_a    = match ? 6'(run_count_r + 6'd1) : 6'd1;
    // padding repeats the byte; it only closes a run when that run is already full
    pad_feed = in_end && pad_r && !odd_r;
    v2       = pad_feed && (cnt_a == pcxrle_pkg::RUN_MAX);
    r2       = '{data: in_byte, count: pcxrle_pkg::RUN_MAX, last: 1'b0};
    if (!pad_feed) begin
      cnt_b = cnt_a;
    end else if (cnt_a == pcxrle_pkg::RUN_MAX) begin
      cnt_b = 6'd1;
    end else begin
      cnt_b = 6'(cnt_a + 6'd1);
    end
    r3    = '{data: in_byte, count: cnt_b, last: 1'b1};
    if (v1) begin
      first = r1;
    end else if (v2) begin
      first = r2;
    end else begin
      first = r3;
    end
  end

  always_comb begin
    run_byte_nxt  = run_byte_r;
    run_count_nxt = run_count_r;
    run_open_nxt  = run_open_r;
    odd_nxt       = odd_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    pend_cnt_nxt  = pend_cnt_r;
    push          = 1'b0;
    push_rec      = first;
    if (pend_cnt_r != 2'd0) begin
      push_rec = p0_r;
      if (!q_stat.full) begin
        push         = 1'b1;
        p0_nxt       = p1_r;
        pend_cnt_nxt = 2'(pend_cnt_r - 2'd1);
      end
    end else if (accept) begin
      push = v1 || in_end;
      if (in_end) begin
        run_byte_nxt  = 8'd0;
        run_count_nxt = 6'd0;
        run_open_nxt  = 1'b0;
        odd_nxt       = 1'b0;
        p0_nxt        = (v1 && v2) ? r2 : r3;
        p1_nxt        = r3;
        pend_cnt_nxt  = {1'b0, v1} + {1'b0, v2};
      end else begin
        run_byte_nxt  = in_byte;
        run_count_nxt = cnt_a;
        run_open_nxt  = 1'b1;
        odd_nxt       = !odd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r       <= 1'b1;
      run_byte_r  <= 8'd0;
      run_count_r <= 6'd0;
      run_open_r  <= 1'b0;
      odd_r       <= 1'b0;
      pend_cnt_r  <= 2'd0;
    end else begin
      if (cfg_valid) begin
        pad_r <= cfg_data;
      end
      run_byte_r  <= run_byte_nxt;
      run_count_r <= run_count_nxt;
      run_open_r  <= run_open_nxt;
      odd_r       <= odd_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
  end

`ifndef SYNTHESIS
  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r |-> (run_count_r != 6'd0))
    else $error("open run with zero count");
  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end) |=> (!run_open_r && !odd_r && pend_cnt_r != 2'd3))
    else $error("row end did not clear run state");
`endif

endmodule

`default_nettype wire

@@ src/pcxrle_fifo.sv @@
// Small register queue of run records between the front end and the emitter.
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_fifo #(
  parameter int DEPTH = pcxrle_pkg::FIFO_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire  pcxrle_pkg::run_rec_t push_rec,
  input  wire                    pop,
  output pcxrle_pkg::run_rec_t   head,
  output pcxrle_pkg::fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pcxrle_pkg::run_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full) && !(pop && stat.empty))
    else $error("queue overrun or underrun");
`endif

endmodule

`default_nettype wire

@@ src/pcxrle_back.sv @@
// Byte emitter: expands run records into literal or count+byte pairs.
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  pcxrle_pkg::run_rec_t   head,
  input  wire  pcxrle_pkg::fifo_stat_t q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  pcxrle_pkg::bk_state_t state_r, state_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       load_ok;
  logic       need_cnt;
  logic       ld;
  logic [7:0] ld_byte;
  logic       ld_last;

  assign load_ok  = !out_valid_r || out_ready;
  // single bytes with both top bits set must still go out as a count pair
  assign need_cnt = (head.count > 6'd1) || (head.data[7:6] == 2'b11);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcxrle_pkg::BK_HEAD: begin
        if (load_ok && !q_stat.empty && need_cnt) begin
          state_nxt = pcxrle_pkg::BK_BYTE;
        end
      end
      pcxrle_pkg::BK_BYTE: begin
        if (load_ok) begin
          state_nxt = pcxrle_pkg::BK_HEAD;
        end
      end
      default: state_nxt = pcxrle_pkg::BK_HEAD;
    endcase
  end

  always_comb begin
    ld      = 1'b0;
    pop     = 1'b0;
    ld_byte = head.data;
    ld_last = head.last;
    case (state_r)
      pcxrle_pkg::BK_HEAD: begin
        if (load_ok && !q_stat.empty) begin
          ld = 1'b1;
          if (need_cnt) begin
            ld_byte = pcxrle_pkg::RUN_MARK | {2'b00, head.count};
            ld_last = 1'b0;
          end else begin
            pop = 1'b1;
          end
        end
      end
      pcxrle_pkg::BK_BYTE: begin
        if (load_ok) begin
          ld  = 1'b1;
          pop = 1'b1;
        end
      end
      default: begin
        ld  = 1'b0;
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcxrle_pkg::BK_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_byte_r <= ld_byte;
      out_last_r <= ld_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_byte_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcxrle_pkg::BK_BYTE) |-> !q_stat.empty)
    else $error("emitter in byte phase with empty queue");
`endif

endmodule

`default_nettype wire

@@ src/pcx_rle_row_encoder.sv @@
// Top level of the PCX run-length row encoder.
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------------
//  input   | in_tvalid/in_tready            | in_tdata=data_byte, in_tlast=row_end
//  output  | out_tvalid/out_tready          | out_tdata=out_byte, out_tlast=last_of_item
//  config  | cfg_valid/cfg_ready            | cfg_data=pad_to_even
//
// The front end takes one byte per cycle while the queue has room and it closes
// at most one run; a row end closing more runs keeps in_tready low until all are queued.
// The emitter sends one byte per cycle unless out_tready stalls; count bytes go first.
// A queue of FIFO_DEPTH run records lets the two sides stall independently.
// Reset (rst_n low, synchronous) empties the queue, drops any open run and sets
// pad_to_even to 1. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module pcx_rle_row_encoder #(
  parameter int FIFO_DEPTH = pcxrle_pkg::FIFO_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_data,     // [0] pad_to_even
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,     // [7:0] data_byte
  input  wire        in_tlast,     // row_end
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,    // [7:0] out_byte
  output logic       out_tlast     // last_of_item
);

  pcxrle_pkg::fifo_stat_t q_stat;
  pcxrle_pkg::run_rec_t   push_rec, head;
  logic                   push, pop;

  assign cfg_ready = 1'b1;

  pcxrle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  pcxrle_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  pcxrle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (out_tdata),
    .out_last (out_tlast)
  );

endmodule

`default_nettype wire

@@ tb/tb_pcx_rle_row_encoder.sv @@
// Self-checking testbench for the PCX run-length row encoder.
`timescale 1ns / 1ps

module tb_pcx_rle_row_encoder;

  localparam logic [5:0] RUN_LIMIT    = 6'd63;
  localparam logic [7:0] COUNT_MARK   = 8'hC0;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         ITEM_TARGET  = 166;
  localparam int         PHASE_ITEMS  = 40;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  typedef enum int {
    RX_ALWAYS,
    RX_HALF,
    RX_MOSTLY,
    RX_SPARSE
  } rx_mode_t;

  // Predicts the encoded byte stream and checks the block's output against it.
  class pcx_rle_scoreboard;
    enc_byte_t  expected_bytes[$];
    logic [7:0] run_byte;
    logic [5:0] run_len;
    logic       run_open;
    logic       odd_row;
    logic       pad_even;
    int         errors;

    function new();
      run_byte = 8'h00;
      run_len  = 6'd0;
      run_open = 1'b0;
      odd_row  = 1'b0;
      pad_even = 1'b1;
      errors   = 0;
    endfunction

    function void set_pad(logic v);
      pad_even = v;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(logic [7:0] v);
      enc_byte_t e;
      e.value = v;
      e.last  = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    function void flush_run();
      if (run_len > 6'd1 || (run_byte & COUNT_MARK) == COUNT_MARK)
        push_byte(COUNT_MARK | {2'b00, run_len});
      push_byte(run_byte);
    endfunction

    function void absorb(logic [7:0] b);
      if (run_open && b == run_byte && run_len < RUN_LIMIT) begin
        run_len = run_len + 6'd1;
      end else begin
        if (run_open)
          flush_run();
        run_byte = b;
        run_len  = 6'd1;
        run_open = 1'b1;
      end
    endfunction

    function void note_request(logic [7:0] d, logic row_end);
      int first;
      first = expected_bytes.size();
      absorb(d);
      odd_row = !odd_row;
      if (row_end) begin
        // pad setting only matters here, at the row end
        if (pad_even && odd_row)
          absorb(d);
        flush_run();
        run_byte = 8'h00;
        run_len  = 6'd0;
        run_open = 1'b0;
        odd_row  = 1'b0;
      end
      if (expected_bytes.size() > first)
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [7:0] v, logic last);
      enc_byte_t e;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output byte, expected none, actual %02h/%0b",
                 $time, v, last);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (v !== e.value) begin
        $display("%0t: out_tdata mismatch, expected %02h, actual %02h", $time, e.value, v);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: out_tlast mismatch, expected %0b, actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic       cfg_data   = 1'b1;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       hold_req   = 1'b0;

  pcx_rle_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;

  pcx_rle_row_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] d, input logic row_end);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= row_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(d, row_end);
    items_sent++;
  endtask

  task automatic send_run(input logic [7:0] d, input int n, input logic close_row);
    int k;
    for (k = 0; k < n; k++)
      send_byte(d, close_row && k == n - 1);
  endtask

  // drain all pending output, then write pad_to_even while the block is quiet
  task automatic write_pad(input logic v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_pad(v);
  endtask

  task automatic send_random_row();
    int runs, n, k, r;
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) begin
      // noise: unstructured bytes with row ends anywhere
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0 || k == n - 1);
    end else begin
      runs = $urandom_range(1, 4);
      for (r = 0; r < runs; r++) begin
        case ($urandom_range(0, 5))
          0:       ; // same byte again, merges with the previous run
          1, 2:    b = 8'($urandom_range(8'hC0, 8'hFF));
          default: b = 8'($urandom_range(0, 255));
        endcase
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
        send_run(b, n, r == runs - 1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tlast);
  end

  initial begin : receiver
    int       hold_left;
    int       mode_left;
    rx_mode_t mode;
    logic     hold_done;
    hold_left = 0;
    mode_left = 0;
    mode      = RX_ALWAYS;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 160;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          default:   out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // padding on (reset value): odd rows get the last byte doubled
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_run(8'h3F, 2, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hC1, 1'b1);
    send_run(8'h80, 2, 1'b0);
    send_run(8'h81, 2, 1'b1);

    write_pad(1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC0, 1'b1);
    send_run(8'h55, 2, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_run(8'h40, 2, 1'b0);

    // register change with a run still open; it takes effect at the row end
    write_pad(1'b1);
    send_byte(8'h40, 1'b1);
    send_byte(8'hBF, 1'b1);

    // receiver goes quiet for a while so the block backs up
    hold_req <= 1'b1;
    phase = 0;
    phase_start = items_sent;
    while (items_sent < ITEM_TARGET) begin
      send_random_row();
      if (items_sent - phase_start >= PHASE_ITEMS) begin
        case (phase)
          0:       write_pad(1'b0);
          1:       write_pad(1'b1);
          default: write_pad(1'($urandom_range(0, 1)));
        endcase
        if (phase == 0)
          send_run(8'hE7, 64, 1'b1); // crosses the 63-byte run limit
        phase++;
        phase_start = items_sent;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
